### rtl/hcbd_pkg.sv
// Shared types, character codes and helpers for the chunked body decoder.
// No dependencies.
package hcbd_pkg;

    localparam int LEN_WIDTH_DEF = 32;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       chunk_done;
        logic       body_end;
        logic       bad_request;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

### rtl/hcbd_core.sv
// Framing state machine of the chunked body decoder: phase, length counter,
// digit flag, and the per-byte result. Depends on hcbd_pkg.
module hcbd_core #(
    parameter int LEN_WIDTH = hcbd_pkg::LEN_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output hcbd_pkg::t_result   o_res
);

    localparam logic [3:0] PH_SIZE     = 4'd0;
    localparam logic [3:0] PH_SIZE_LF  = 4'd1;
    localparam logic [3:0] PH_EXT      = 4'd2;
    localparam logic [3:0] PH_EXT_CR   = 4'd3;
    localparam logic [3:0] PH_DATA     = 4'd4;
    localparam logic [3:0] PH_DATA_CR  = 4'd5;
    localparam logic [3:0] PH_DATA_LF  = 4'd6;
    localparam logic [3:0] PH_FINAL_CR = 4'd7;
    localparam logic [3:0] PH_FINAL_LF = 4'd8;
    localparam logic [3:0] PH_DONE     = 4'd9;
    localparam logic [3:0] PH_ERROR    = 4'd10;

    logic [3:0]           r_phase, n_phase;
    logic [LEN_WIDTH-1:0] r_len, n_len;
    logic                 r_digit, n_digit;

    hcbd_pkg::t_hex hex;
    logic [LEN_WIDTH-1:0] len_dec;
    logic err;

    assign hex     = hcbd_pkg::hex_decode(i_byte);
    assign len_dec = r_len - LEN_WIDTH'(1);

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_digit = r_digit;
        err     = 1'b0;
        o_res   = '0;
        unique case (r_phase)
            PH_SIZE: begin
                if (hex.ok) begin
                    // next digit would shift bits out of the counter
                    if (r_len[LEN_WIDTH-1 -: 4] != 4'd0) begin
                        err = 1'b1;
                    end else begin
                        n_len   = {r_len[LEN_WIDTH-5:0], hex.val};
                        n_digit = 1'b1;
                    end
                end else if (i_byte == hcbd_pkg::CH_SEMI && r_digit) begin
                    n_phase = PH_EXT;
                end else if (i_byte == hcbd_pkg::CH_CR && r_digit) begin
                    n_phase = PH_SIZE_LF;
                end else begin
                    err = 1'b1;
                end
            end
            PH_SIZE_LF: begin
                if (i_byte == hcbd_pkg::CH_LF) begin
                    n_phase = (r_len == '0) ? PH_FINAL_CR : PH_DATA;
                end else begin
                    err = 1'b1;
                end
            end
            PH_EXT: begin
                if (i_byte == hcbd_pkg::CH_CR) n_phase = PH_EXT_CR;
            end
            PH_EXT_CR: begin
                if (i_byte == hcbd_pkg::CH_LF) begin
                    n_phase = (r_len == '0) ? PH_FINAL_CR : PH_DATA;
                end else if (i_byte != hcbd_pkg::CH_CR) begin
                    n_phase = PH_EXT;
                end
            end
            PH_DATA: begin
                o_res.payload_byte  = i_byte;
                o_res.payload_valid = 1'b1;
                n_len = len_dec;
                if (len_dec == '0) n_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
                if (i_byte == hcbd_pkg::CH_CR) n_phase = PH_DATA_LF;
                else err = 1'b1;
            end
            PH_DATA_LF: begin
                if (i_byte == hcbd_pkg::CH_LF) begin
                    o_res.chunk_done = 1'b1;
                    n_phase = PH_SIZE;
                    n_len   = '0;
                    n_digit = 1'b0;
                end else begin
                    err = 1'b1;
                end
            end
            PH_FINAL_CR: begin
                if (i_byte == hcbd_pkg::CH_CR) n_phase = PH_FINAL_LF;
                else err = 1'b1;
            end
            PH_FINAL_LF: begin
                if (i_byte == hcbd_pkg::CH_LF) begin
                    o_res.body_end = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    err = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
                err = 1'b1;
            end
        endcase
        if (err) begin
            n_phase = PH_ERROR;
            o_res   = '0;
            o_res.bad_request = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_len   <= '0;
            r_digit <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_digit <= n_digit;
        end
    end

endmodule

### rtl/http_chunked_body_decoder_unit.sv
// The result is registered: each input byte passes the input register, then
// the result register, and a stalled result side can hold it between them.
// Throughput: one byte per cycle, no bubbles while the result side takes a
// transfer every cycle. Synchronous active-low reset returns the decoder
// to the first size digit with an empty pipeline; an error holds until reset.
// Depends on hcbd_pkg and hcbd_core.
module http_chunked_body_decoder_unit #(
    parameter int LEN_WIDTH = hcbd_pkg::LEN_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_valid,
    output logic       o_chunk_done,
    output logic       o_body_end,
    output logic       o_bad_request
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_out_vld;
    hcbd_pkg::t_result r_out;
    hcbd_pkg::t_result res;
    logic              out_load;

    // stage advances when the result register is free or drains this cycle
    assign out_load = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready  = !r_in_vld || out_load;

    hcbd_core #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (out_load),
        .i_byte (r_in_byte),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in_byte <= i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= res;
    end

    assign o_valid         = r_out_vld;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_valid = r_out.payload_valid;
    assign o_chunk_done    = r_out.chunk_done;
    assign o_body_end      = r_out.body_end;
    assign o_bad_request   = r_out.bad_request;

endmodule

### rtl/hcbd_checker.sv
// Port-level checks on the chunked body decoder result stream, and the bind
// that attaches them to the top level. Depends on http_chunked_body_decoder_unit through the bind.
module hcbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_payload_byte,
    input logic       o_payload_valid,
    input logic       o_chunk_done,
    input logic       o_body_end,
    input logic       o_bad_request
);

    logic r_seen_err;
    logic r_seen_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_err <= 1'b0;
            r_seen_end <= 1'b0;
        end else if (o_valid && i_ready) begin
            if (o_bad_request) r_seen_err <= 1'b1;
            if (o_body_end)    r_seen_end <= 1'b1;
        end
    end

    // a stalled result stays valid and keeps its payload byte, payload flag and error flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_payload_byte)
            && $stable(o_bad_request) && $stable(o_payload_valid)))
        else $error("result changed while stalled");

    // at most one flag per result
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_payload_valid, o_chunk_done, o_body_end, o_bad_request}))
        else $error("conflicting result flags");

    // error is sticky
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_seen_err) |-> o_bad_request)
        else $error("bad_request dropped after error");

    // after body end, everything stays quiet
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_seen_end) |-> (!o_payload_valid && !o_chunk_done
            && !o_body_end && !o_bad_request && o_payload_byte == 8'd0))
        else $error("activity after body end");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_payload_byte (o_payload_byte),
    .o_payload_valid(o_payload_valid),
    .o_chunk_done   (o_chunk_done),
    .o_body_end     (o_body_end),
    .o_bad_request  (o_bad_request)
);

### bench/chunk_decode_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the chunked body decoder, predicts each result from the
// transferred body bytes, and compares results in order. Depends on hcbd_pkg.
module chunk_decode_checker #(
    parameter int LEN_WIDTH = hcbd_pkg::LEN_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic       i_byte_ready,
    input  logic [7:0] i_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_payload_byte,
    input  logic       i_payload_valid,
    input  logic       i_chunk_done,
    input  logic       i_body_end,
    input  logic       i_bad_request,
    output int         o_fail_count,
    output int         o_pending
);

    typedef enum logic [3:0] {
        FR_SIZE, FR_SIZE_LF, FR_EXT, FR_EXT_CR, FR_DATA, FR_DATA_CR, FR_DATA_LF,
        FR_FINAL_CR, FR_FINAL_LF, FR_DONE, FR_ERROR
    } t_frame_phase;

    t_frame_phase         frame;
    logic [LEN_WIDTH-1:0] chunk_left;
    logic                 size_digit_seen;
    hcbd_pkg::t_result    decoded_q[$];
    hcbd_pkg::t_result    seen_res;
    hcbd_pkg::t_result    want_res;
    int                   res_index;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        res_index    = 0;
    end

    // Advances the framing state by one body byte and returns the result it causes.
    function automatic hcbd_pkg::t_result decode_byte(input logic [7:0] b);
        hcbd_pkg::t_result r;
        logic              bad;
        logic              is_hex;
        logic [3:0]        nib;
        r      = '0;
        bad    = 1'b0;
        is_hex = 1'b1;
        nib    = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin          // '0'..'9'
            nib = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin // 'A'..'F'
            nib = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin // 'a'..'f'
            nib = 4'(b - 8'h57);
        end else begin
            is_hex = 1'b0;
        end

        case (frame)
            FR_SIZE: begin
                if (is_hex) begin
                    // next shift would push a set bit out of the length register
                    if (chunk_left[LEN_WIDTH-1 -: 4] != 4'd0) begin
                        bad = 1'b1;
                    end else begin
                        chunk_left      = {chunk_left[LEN_WIDTH-5:0], nib};
                        size_digit_seen = 1'b1;
                    end
                end else if (b == hcbd_pkg::CH_SEMI && size_digit_seen) begin
                    frame = FR_EXT;
                end else if (b == hcbd_pkg::CH_CR && size_digit_seen) begin
                    frame = FR_SIZE_LF;
                end else begin
                    bad = 1'b1;
                end
            end
            FR_SIZE_LF: begin
                if (b == hcbd_pkg::CH_LF) frame = (chunk_left == '0) ? FR_FINAL_CR : FR_DATA;
                else bad = 1'b1;
            end
            FR_EXT: begin
                if (b == hcbd_pkg::CH_CR) frame = FR_EXT_CR;
            end
            FR_EXT_CR: begin
                if (b == hcbd_pkg::CH_LF) frame = (chunk_left == '0) ? FR_FINAL_CR : FR_DATA;
                else if (b != hcbd_pkg::CH_CR) frame = FR_EXT;
            end
            FR_DATA: begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                chunk_left      = chunk_left - LEN_WIDTH'(1);
                if (chunk_left == '0) frame = FR_DATA_CR;
            end
            FR_DATA_CR: begin
                if (b == hcbd_pkg::CH_CR) frame = FR_DATA_LF;
                else bad = 1'b1;
            end
            FR_DATA_LF: begin
                if (b == hcbd_pkg::CH_LF) begin
                    r.chunk_done    = 1'b1;
                    frame           = FR_SIZE;
                    chunk_left      = '0;
                    size_digit_seen = 1'b0;
                end else begin
                    bad = 1'b1;
                end
            end
            FR_FINAL_CR: begin
                if (b == hcbd_pkg::CH_CR) frame = FR_FINAL_LF;
                else bad = 1'b1;
            end
            FR_FINAL_LF: begin
                if (b == hcbd_pkg::CH_LF) begin
                    r.body_end = 1'b1;
                    frame      = FR_DONE;
                end else begin
                    bad = 1'b1;
                end
            end
            FR_DONE: ;
            default: bad = 1'b1;
        endcase

        if (bad) begin
            frame         = FR_ERROR;
            r             = '0;
            r.bad_request = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] result %0d: %s is %0h, predicted %0h",
                 $realtime, res_index, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame           = FR_SIZE;
            chunk_left      = '0;
            size_digit_seen = 1'b0;
            decoded_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                seen_res = {i_payload_byte, i_payload_valid, i_chunk_done, i_body_end,
                            i_bad_request};
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 8'd0, 8'd0);
                end else begin
                    want_res = decoded_q.pop_front();
                    if (seen_res.payload_byte !== want_res.payload_byte)
                        report_mismatch("payload_byte", seen_res.payload_byte,
                                        want_res.payload_byte);
                    if (seen_res.payload_valid !== want_res.payload_valid)
                        report_mismatch("payload_valid", 8'(seen_res.payload_valid),
                                        8'(want_res.payload_valid));
                    if (seen_res.chunk_done !== want_res.chunk_done)
                        report_mismatch("chunk_done", 8'(seen_res.chunk_done),
                                        8'(want_res.chunk_done));
                    if (seen_res.body_end !== want_res.body_end)
                        report_mismatch("body_end", 8'(seen_res.body_end),
                                        8'(want_res.body_end));
                    if (seen_res.bad_request !== want_res.bad_request)
                        report_mismatch("bad_request", 8'(seen_res.bad_request),
                                        8'(want_res.bad_request));
                end
                res_index++;
            end
            if (i_byte_valid && i_byte_ready) begin
                decoded_q.push_back(decode_byte(i_byte));
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Top of the chunked body decoder bench: clock, reset, body byte stimulus and verdict.
// Depends on hcbd_pkg, http_chunked_body_decoder_unit and chunk_decode_checker.
module testbench;

    localparam int CYCLE_LIMIT = 1_000_000;

    // how the body is closed; errors are sticky, so each run ends one way
    typedef enum int {
        END_CLEAN, END_EMPTY_SIZE, END_BAD_SIZE_CHAR, END_OVERSIZE,
        END_NO_SIZE_LF, END_NO_DATA_CRLF, END_NO_FINAL_CRLF
    } t_ending;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_payload_byte;
    logic       o_payload_valid;
    logic       o_chunk_done;
    logic       o_body_end;
    logic       o_bad_request;

    int      fail_count;
    int      pending;
    int      bytes_sent;
    int      chunks_sent;
    int      cycles;
    bit      sender_calm;
    t_ending ending;

    http_chunked_body_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_payload_byte  (o_payload_byte),
        .o_payload_valid (o_payload_valid),
        .o_chunk_done    (o_chunk_done),
        .o_body_end      (o_body_end),
        .o_bad_request   (o_bad_request)
    );

    chunk_decode_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_valid    (i_valid),
        .i_byte_ready    (o_ready),
        .i_byte          (i_data_byte),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_payload_byte  (o_payload_byte),
        .i_payload_valid (o_payload_valid),
        .i_chunk_done    (o_chunk_done),
        .i_body_end      (o_body_end),
        .i_bad_request   (o_bad_request),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + {4'd0, nib};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
    endfunction

    // Entered and left at a falling edge; valid stays up between back-to-back transfers.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 60) gap = 0;
        else if (r < 93) gap = $urandom_range(1, 3);
        else gap = $urandom_range(6, 30);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic push_size(input logic [31:0] value);
        int nd;
        int zeros;
        nd = 1;
        while (nd < 8 && (value >> (4 * nd)) != 0) nd++;
        zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        repeat (zeros) push_byte(8'h30);
        for (int i = nd - 1; i >= 0; i--) push_byte(hex_char(value[4*i +: 4]));
    endtask

    // ';' then extension text up to CR LF, sometimes with a lone CR or a doubled CR
    task automatic push_extension();
        int         n;
        logic [7:0] c;
        push_byte(hcbd_pkg::CH_SEMI);
        n = $urandom_range(0, 6);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                push_byte(hcbd_pkg::CH_CR);
                c = 8'h20 + 8'($urandom_range(0, 94));
            end else begin
                do c = 8'($urandom_range(0, 255)); while (c == hcbd_pkg::CH_CR);
            end
            push_byte(c);
        end
        if ($urandom_range(0, 3) == 0) push_byte(hcbd_pkg::CH_CR);
        push_byte(hcbd_pkg::CH_CR);
        push_byte(hcbd_pkg::CH_LF);
    endtask

    // a CR LF that goes wrong, either at the CR or at the LF
    task automatic push_broken_crlf();
        logic [7:0] c;
        if ($urandom_range(0, 1)) begin
            do c = 8'($urandom_range(0, 255)); while (c == hcbd_pkg::CH_CR);
        end else begin
            push_byte(hcbd_pkg::CH_CR);
            do c = 8'($urandom_range(0, 255)); while (c == hcbd_pkg::CH_LF);
        end
        push_byte(c);
    endtask

    // receiver side: random stalls, calm stretches, one long hold-off
    initial begin
        int  stall_left;
        int  rx_cycle;
        bit  held;
        bit  calm;
        int  r;
        stall_left = 0;
        rx_cycle   = 0;
        held       = 1'b0;
        calm       = 1'b0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            if (!held && bytes_sent >= 500) begin
                held       = 1'b1;
                stall_left = 250;
            end
            if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else if (calm) begin
                i_ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_ready = 1'b1;
                end else begin
                    i_ready    = 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    initial begin
        logic [31:0] size;
        logic [7:0]  c;
        int          junk;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'h00;
        bytes_sent  = 0;
        chunks_sent = 0;
        sender_calm = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // leading zeros, payload extremes
        push_byte(8'h30); push_byte(8'h30); push_byte(8'h32);
        push_byte(hcbd_pkg::CH_CR); push_byte(hcbd_pkg::CH_LF);
        push_byte(8'h00); push_byte(8'hFF);
        push_byte(hcbd_pkg::CH_CR); push_byte(hcbd_pkg::CH_LF);
        // extension with a lone CR and a doubled CR; framing bytes as payload
        push_byte(8'h33); push_byte(hcbd_pkg::CH_SEMI); push_byte(8'h78);
        push_byte(hcbd_pkg::CH_CR); push_byte(8'h71);
        push_byte(hcbd_pkg::CH_CR); push_byte(hcbd_pkg::CH_CR);
        push_byte(hcbd_pkg::CH_LF);
        push_byte(hcbd_pkg::CH_CR); push_byte(hcbd_pkg::CH_LF);
        push_byte(hcbd_pkg::CH_SEMI);
        push_byte(hcbd_pkg::CH_CR); push_byte(hcbd_pkg::CH_LF);
        chunks_sent = 2;

        // well-formed chunks with random sizes, extensions and content
        while (bytes_sent < 1600) begin
            sender_calm = ($urandom_range(0, 4) == 0);
            size = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 300)
                                                : $urandom_range(1, 24);
            push_size(size);
            if ($urandom_range(0, 3) == 0) begin
                push_extension();
            end else begin
                push_byte(hcbd_pkg::CH_CR);
                push_byte(hcbd_pkg::CH_LF);
            end
            repeat (size) push_byte(8'($urandom_range(0, 255)));
            push_byte(hcbd_pkg::CH_CR);
            push_byte(hcbd_pkg::CH_LF);
            chunks_sent++;
        end

        sender_calm = 1'b0;
        ending = t_ending'($urandom_range(0, END_NO_FINAL_CRLF));
        case (ending)
            END_CLEAN: begin
                push_byte(8'h30);
                if ($urandom_range(0, 1)) begin
                    push_extension();
                end else begin
                    push_byte(hcbd_pkg::CH_CR);
                    push_byte(hcbd_pkg::CH_LF);
                end
                push_byte(hcbd_pkg::CH_CR);
                push_byte(hcbd_pkg::CH_LF);
            end
            END_EMPTY_SIZE: begin
                push_byte($urandom_range(0, 1) ? hcbd_pkg::CH_SEMI : hcbd_pkg::CH_CR);
            end
            END_BAD_SIZE_CHAR: begin
                if ($urandom_range(0, 1)) push_size($urandom_range(1, 255));
                do c = 8'($urandom_range(0, 255));
                while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                       (c >= 8'h61 && c <= 8'h66) || c == hcbd_pkg::CH_CR ||
                       c == hcbd_pkg::CH_SEMI);
                push_byte(c);
            end
            END_OVERSIZE: begin
                // nine digits starting with 1: the ninth overflows 32 bits
                push_byte(8'h31);
                repeat (8) push_byte(hex_char(4'($urandom_range(0, 15))));
            end
            END_NO_SIZE_LF: begin
                push_size($urandom_range(1, 255));
                push_byte(hcbd_pkg::CH_CR);
                do c = 8'($urandom_range(0, 255)); while (c == hcbd_pkg::CH_LF);
                push_byte(c);
            end
            END_NO_DATA_CRLF: begin
                size = $urandom_range(1, 8);
                push_size(size);
                push_byte(hcbd_pkg::CH_CR);
                push_byte(hcbd_pkg::CH_LF);
                repeat (size) push_byte(8'($urandom_range(0, 255)));
                push_broken_crlf();
            end
            default: begin
                push_byte(8'h30);
                push_byte(hcbd_pkg::CH_CR);
                push_byte(hcbd_pkg::CH_LF);
                push_broken_crlf();
            end
        endcase

        // bytes past the end or past the error
        junk = $urandom_range(10, 30);
        repeat (junk) push_byte(8'($urandom_range(0, 255)));
        i_valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("sent %0d body bytes in %0d chunks, closed by %s, then %0d stray bytes",
                 bytes_sent, chunks_sent, ending.name(), junk);
        $display("%0d mismatches over %0d cycles", fail_count, cycles);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
